// ===== design/chull_pkg.sv =====
package chull_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_OUT         = 64;

endpackage

// ===== design/chull_turn.sv =====
// Shared cross product unit, in three registered steps from start to done:
// the differences, then the two products, then the sign, which is valid with done.
module chull_turn #(
    parameter int CW = chull_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] ox,
    input  logic signed [CW-1:0] oy,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by,
    output logic                 done,
    output logic                 negative
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic [1:0] stage_reg;
    logic       neg_reg;
    logic       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 2'b00;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[0], start};
            done_reg  <= stage_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        dax_reg <= DW'(ax) - DW'(ox);
        day_reg <= DW'(ay) - DW'(oy);
        dbx_reg <= DW'(bx) - DW'(ox);
        dby_reg <= DW'(by) - DW'(oy);
        p1_reg  <= PW'(dax_reg) * PW'(dby_reg);
        p2_reg  <= PW'(day_reg) * PW'(dbx_reg);
        neg_reg <= p1_reg < p2_reg;
    end

    assign done     = done_reg;
    assign negative = neg_reg;

endmodule

// ===== design/convex_hull_monotone_chain.sv =====
// Convex hull by the monotone chain method.
// Input channel (in_valid/in_ready) carries points point_x, point_y, last_point.
// Points are stored, one transfer per cycle while in_ready is high, until one carries last_point.
// A point that arrives when MAX_POINTS points are held is dropped and the
// run's results carry points_dropped.
// After the last point the block sorts the set with an insertion sort that
// compares and moves one entry per cycle through the point memory, then
// walks the lower and upper chains using one shared cross product unit;
// each point is read and pushed after turn tests against the top two stack
// entries, and every turn test that finds a clockwise turn pops a vertex.
// Results leave on out_valid/out_ready, counter-clockwise, from the leftmost point
// (lowest y on a tie), the first vertex not repeated; the final one carries last_vertex.
// A set of fewer than two points yields one transfer with hull_empty set.
// The insertion sort makes the run time grow with n*n for n points, most for
// reversed input, and each popped vertex adds one more turn test.
// Results leave one at a time, each read from the stack before it is offered.
// in_ready is low from the last point until the final result is taken.
// When the receiver stalls the result register holds; the block waits.
// Reset clears the point count and all control state; memories are not
// cleared since only written entries are ever read.
module convex_hull_monotone_chain #(
    parameter int MAX_POINTS  = chull_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = chull_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] vertex_x,
    output logic signed [COORD_WIDTH-1:0] vertex_y,
    output logic                          last_vertex,
    output logic                          hull_empty,
    output logic                          points_dropped
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SD = 2 * MAX_POINTS;
    localparam int SW = $clog2(SD + 1);
    localparam int SAW = $clog2(SD);
    localparam int OW = $clog2(chull_pkg::MAX_OUT + 1);
    localparam int CMPW = (SW > OW) ? SW : OW;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } pt_t;

    typedef enum logic [4:0] {
        S_LOAD, S_SORT_RD, S_SORT_WT, S_SORT_CMP, S_SORT_PLACE,
        S_H_RDP, S_H_WTP, S_H_CHK, S_H_RDA, S_H_RDB, S_H_WTB, S_H_TURN, S_H_WAIT,
        S_H_PUSH, S_E_RD, S_E_WT, S_E_OUT, S_EMPTY
    } state_t;

    pt_t pstore [MAX_POINTS];
    pt_t hstack [SD];

    state_t          state_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            ovf_reg;
    logic            drop_reg;
    logic [AW-1:0]   i_reg, q_reg;
    pt_t             v_reg;
    pt_t             prd_reg;
    logic [AW-1:0]   prd_addr;
    logic [SW-1:0]   k_reg, t_reg;
    logic            upper_reg;
    logic [AW-1:0]   j_reg;
    pt_t             sa_reg, sb_reg, srd_reg;
    logic [SW-1:0]   srd_addr;
    logic [OW-1:0]   emit_reg, e_reg;
    logic            ovalid_reg, olast_reg, oempty_reg;
    pt_t             odata_reg;
    logic            t_start;
    logic            t_done, t_neg;
    logic            pwe;
    logic [AW-1:0]   pwa;
    pt_t             pwd;
    logic            swe;
    pt_t             swd;
    logic            before_v;
    logic            accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_LOAD) && !ovalid_reg;
    assign before_v = (v_reg.x < prd_reg.x) || ((v_reg.x == prd_reg.x) && (v_reg.y < prd_reg.y));

    // Point memory: one write and one registered read per cycle.
    always_comb
    begin
        pwe = 1'b0;
        pwa = q_reg;
        pwd = v_reg;
        prd_addr = i_reg;
        case (state_reg)
            S_LOAD:
            begin
                pwe = accept && (cnt_reg < CNTW'(MAX_POINTS));
                pwa = AW'(cnt_reg);
                pwd = '{x: point_x, y: point_y};
            end
            S_SORT_RD:    prd_addr = i_reg;
            S_SORT_WT:    prd_addr = q_reg - AW'(1);
            S_SORT_CMP:
            begin
                pwe = (q_reg != '0) && before_v;
                pwd = prd_reg;
                prd_addr = q_reg - AW'(2);
            end
            S_SORT_PLACE: pwe = 1'b1;
            S_H_RDP:      prd_addr = j_reg;
            default:      prd_addr = j_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
            pstore[pwa] <= pwd;
        prd_reg <= pstore[prd_addr];
    end

    // Stack memory.
    always_comb
    begin
        case (state_reg)
            S_H_RDA: srd_addr = k_reg - SW'(2);
            S_H_RDB: srd_addr = k_reg - SW'(1);
            default: srd_addr = SW'(e_reg);
        endcase
        swe = (state_reg == S_H_PUSH);
        swd = v_reg;
    end

    // The stack never holds more than 2*MAX_POINTS-1 entries.
    always_ff @(posedge clk)
    begin
        if (swe)
            hstack[k_reg[SAW-1:0]] <= swd;
        srd_reg <= hstack[srd_addr[SAW-1:0]];
    end

    assign t_start = (state_reg == S_H_TURN);

    chull_turn #(.CW(CW)) u_turn (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (t_start),
        .ox       (sa_reg.x),
        .oy       (sa_reg.y),
        .ax       (sb_reg.x),
        .ay       (sb_reg.y),
        .bx       (v_reg.x),
        .by       (v_reg.y),
        .done     (t_done),
        .negative (t_neg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            drop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            oempty_reg <= 1'b0;
            i_reg      <= '0;
            q_reg      <= '0;
            k_reg      <= '0;
            t_reg      <= '0;
            j_reg      <= '0;
            upper_reg  <= 1'b0;
            emit_reg   <= '0;
            e_reg      <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        logic [CNTW-1:0] n;
                        n = cnt_reg;
                        if (cnt_reg < CNTW'(MAX_POINTS))
                            n = cnt_reg + CNTW'(1);
                        cnt_reg <= n;
                        if (last_point)
                        begin
                            drop_reg <= ovf_reg || (cnt_reg >= CNTW'(MAX_POINTS));
                            ovf_reg  <= 1'b0;
                            if (n < CNTW'(2))
                                state_reg <= S_EMPTY;
                            else
                            begin
                                i_reg     <= AW'(1);
                                state_reg <= S_SORT_RD;
                            end
                        end
                        else if (cnt_reg >= CNTW'(MAX_POINTS))
                            ovf_reg <= 1'b1;
                    end
                end
                S_EMPTY:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= '0;
                        olast_reg  <= 1'b1;
                        oempty_reg <= 1'b1;
                        cnt_reg    <= '0;
                        state_reg  <= S_LOAD;
                    end
                end
                S_SORT_RD:
                begin
                    q_reg     <= i_reg;
                    state_reg <= S_SORT_WT;
                end
                S_SORT_WT:
                begin
                    v_reg     <= prd_reg;
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    if ((q_reg != '0) && before_v)
                        q_reg <= q_reg - AW'(1);
                    else
                        state_reg <= S_SORT_PLACE;
                end
                S_SORT_PLACE:
                begin
                    if (CNTW'(i_reg) + CNTW'(1) >= cnt_reg)
                    begin
                        j_reg     <= '0;
                        k_reg     <= '0;
                        upper_reg <= 1'b0;
                        state_reg <= S_H_RDP;
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= S_SORT_RD;
                    end
                end
                S_H_RDP:  state_reg <= S_H_WTP;
                S_H_WTP:
                begin
                    v_reg     <= prd_reg;
                    state_reg <= S_H_CHK;
                end
                S_H_CHK:
                begin
                    if (upper_reg ? (k_reg >= t_reg) : (k_reg >= SW'(2)))
                        state_reg <= S_H_RDA;
                    else
                        state_reg <= S_H_PUSH;
                end
                S_H_RDA:  state_reg <= S_H_RDB;
                S_H_RDB:
                begin
                    sa_reg    <= srd_reg;
                    state_reg <= S_H_WTB;
                end
                S_H_WTB:
                begin
                    sb_reg    <= srd_reg;
                    state_reg <= S_H_TURN;
                end
                S_H_TURN: state_reg <= S_H_WAIT;
                S_H_WAIT:
                begin
                    if (t_done)
                    begin
                        if (t_neg)
                        begin
                            k_reg     <= k_reg - SW'(1);
                            state_reg <= S_H_CHK;
                        end
                        else
                            state_reg <= S_H_PUSH;
                    end
                end
                S_H_PUSH:
                begin
                    k_reg <= k_reg + SW'(1);
                    state_reg <= S_H_RDP;
                    if (!upper_reg)
                    begin
                        if (CNTW'(j_reg) + CNTW'(1) >= cnt_reg)
                        begin
                            upper_reg <= 1'b1;
                            t_reg     <= k_reg + SW'(2);
                            j_reg     <= AW'(cnt_reg - CNTW'(2));
                        end
                        else
                            j_reg <= j_reg + AW'(1);
                    end
                    else if (j_reg == '0)
                    begin
                        // k after push minus one closing vertex
                        emit_reg  <= (CMPW'(k_reg) > CMPW'(chull_pkg::MAX_OUT))
                                     ? OW'(chull_pkg::MAX_OUT) : OW'(k_reg);
                        e_reg     <= '0;
                        state_reg <= S_E_RD;
                    end
                    else
                        j_reg <= j_reg - AW'(1);
                end
                S_E_RD:   state_reg <= S_E_WT;
                S_E_WT:   state_reg <= S_E_OUT;
                S_E_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= srd_reg;
                        oempty_reg <= 1'b0;
                        olast_reg  <= (e_reg + OW'(1) == emit_reg);
                        if (e_reg + OW'(1) == emit_reg)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            e_reg     <= e_reg + OW'(1);
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default:  state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid      = ovalid_reg;
    assign vertex_x       = odata_reg.x;
    assign vertex_y       = odata_reg.y;
    assign last_vertex    = olast_reg;
    assign hull_empty     = oempty_reg;
    assign points_dropped = drop_reg;

`ifndef NO_ASSERTIONS
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hull_empty) |-> last_vertex)
        else $error("empty result not marked last");
    a_turn_done: assert property (@(posedge clk) disable iff (!rst_n)
        t_start |=> ##2 t_done)
        else $error("cross product unit latency wrong");
`endif

endmodule
